// File: sv/averaged_sensor_seek_controller_top_assert.svh
// assertion macros shared by the seek controller modules
`ifndef AVERAGED_SENSOR_SEEK_CONTROLLER_TOP_ASSERT_SVH
`define AVERAGED_SENSOR_SEEK_CONTROLLER_TOP_ASSERT_SVH

// plain property, checked out of reset
`define ASC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define ASC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/asc_pkg.sv
// types and constants of the averaged sensor seek controller
`default_nettype none

package asc_pkg;

  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned AVG_W      = 12;
  localparam int unsigned PINS_W     = 7;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned LEVEL_W    = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIMER_W-1:0] SEARCH_SAMPLES_RST = 16'd50;
  localparam logic [LEVEL_W-1:0] APPROACH_MARGIN_RST = 12'd200;
  localparam logic [LEVEL_W-1:0] STOP_THRESHOLD_RST = 12'd950;
  localparam logic [PINS_W-1:0]  TURN_PATTERN_RST = 7'd10;
  localparam logic [PINS_W-1:0]  DRIVE_PATTERN_RST = 7'd6;

  typedef enum logic [MODE_W-1:0] {
    MODE_SEARCH = 2'd0,
    MODE_SPIN   = 2'd1,
    MODE_GO     = 2'd2,
    MODE_DONE   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_SAMPLES  = 3'd0,
    CFG_APPROACH_MARGIN = 3'd1,
    CFG_STOP_THRESHOLD  = 3'd2,
    CFG_TURN_PATTERN    = 3'd3,
    CFG_DRIVE_PATTERN   = 3'd4
  } cfg_idx_e;

  // accumulator stage status toward the seek stage
  typedef struct packed {
    logic valid;
    logic blk_done;
  } acc_ctl_t;

endpackage

`default_nettype wire

// File: sv/asc_sample_if.sv
// sample channel: four adc samples per item
`default_nettype none

interface asc_sample_if import asc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_ch0;
  logic [SAMPLE_W-1:0] sample_ch1;
  logic [SAMPLE_W-1:0] sample_ch2;
  logic [SAMPLE_W-1:0] sample_ch3;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/asc_result_if.sv
// result channel: motor pins, mode, averages and peak per item
`default_nettype none

interface asc_result_if import asc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PINS_W-1:0] motor_pins;
  logic [MODE_W-1:0] mode;
  logic              avg_valid;
  logic [AVG_W-1:0]  avg_ch0;
  logic [AVG_W-1:0]  avg_ch1;
  logic [AVG_W-1:0]  avg_ch2;
  logic [AVG_W-1:0]  avg_ch3;
  logic [AVG_W-1:0]  peak_value;

  modport source (
    output valid, motor_pins, mode, avg_valid, avg_ch0, avg_ch1, avg_ch2, avg_ch3,
           peak_value,
    input  ready
  );
  modport sink (
    input  valid, motor_pins, mode, avg_valid, avg_ch0, avg_ch1, avg_ch2, avg_ch3,
           peak_value,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/asc_accum.sv
// block accumulator: per-channel running sums and block counter
`default_nettype none
`include "averaged_sensor_seek_controller_top_assert.svh"

module asc_accum import asc_pkg::*; #(
  parameter int unsigned BLOCK_LEN   = 10,
  parameter int unsigned SAMPLE_BITS = 12,
  localparam int unsigned EFF_BITS   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W,
  localparam int unsigned SUM_W      = EFF_BITS + $clog2(BLOCK_LEN)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  asc_sample_if.sink          sample_i,
  input  wire logic           take_i,
  output acc_ctl_t            ctl_o,
  output logic [SUM_W-1:0]    sum_o [NUM_CH]
);

  localparam int unsigned CNT_W = $clog2(BLOCK_LEN);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BLOCK_LEN - 1);

  logic [SUM_W-1:0]    sums_q [NUM_CH];
  logic [SUM_W-1:0]    acc_sum [NUM_CH];
  logic [SUM_W-1:0]    s1_sum_q [NUM_CH];
  logic [SAMPLE_W-1:0] smp [NUM_CH];
  logic [CNT_W-1:0]    count_q;
  acc_ctl_t            ctl_q;
  logic                last;
  logic                accept;

  assign smp[0] = sample_i.sample_ch0;
  assign smp[1] = sample_i.sample_ch1;
  assign smp[2] = sample_i.sample_ch2;
  assign smp[3] = sample_i.sample_ch3;

  // samples narrower than the port keep only their low bits
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc_sum[ch] = sums_q[ch] + SUM_W'(smp[ch][EFF_BITS-1:0]);
    end
  end

  assign last           = (count_q == LAST_CNT);
  assign sample_i.ready = !ctl_q.valid || take_i;
  assign accept         = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        sums_q[ch] <= '0;
      end
    end else if (accept) begin
      if (last) begin
        count_q <= '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          sums_q[ch] <= '0;
        end
      end else begin
        count_q <= count_q + 1'b1;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          sums_q[ch] <= acc_sum[ch];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (accept) begin
      ctl_q.valid    <= 1'b1;
      ctl_q.blk_done <= last;
    end else if (take_i) begin
      ctl_q.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s1_sum_q[ch] <= acc_sum[ch];
      end
    end
  end

  assign ctl_o = ctl_q;
  assign sum_o = s1_sum_q;

  `ASC_ASSERT(a_cnt_range, count_q <= LAST_CNT, "block counter out of range")
  `ASC_ASSERT_IMPLY(a_done_cnt_zero, ctl_q.valid && ctl_q.blk_done, count_q == '0,
                    "completed block held while counter not restarted")

endmodule

`default_nettype wire

// File: sv/asc_seek.sv
// averaging, peak tracking, mode machine, config registers and result register
`default_nettype none
`include "averaged_sensor_seek_controller_top_assert.svh"

module asc_seek import asc_pkg::*; #(
  parameter int unsigned BLOCK_LEN   = 10,
  parameter int unsigned SAMPLE_BITS = 12,
  localparam int unsigned EFF_BITS   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W,
  localparam int unsigned SUM_W      = EFF_BITS + $clog2(BLOCK_LEN)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire acc_ctl_t              ctl_i,
  input  wire logic [SUM_W-1:0]      sum_i [NUM_CH],
  output logic                       take_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  asc_result_if.source               result_o
);

  // floor(sum / BLOCK_LEN) as a multiply by a rounded-up reciprocal, exact for sum < 2**SUM_W
  localparam int unsigned SHIFT   = SUM_W + $clog2(BLOCK_LEN);
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C =
    RECIP_W'(((64'd1 << SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));

  logic [TIMER_W-1:0] search_samples_q;
  logic [LEVEL_W-1:0] approach_margin_q;
  logic [LEVEL_W-1:0] stop_threshold_q;
  logic [PINS_W-1:0]  turn_pattern_q;
  logic [PINS_W-1:0]  drive_pattern_q;

  logic [PROD_W-1:0]  prod [NUM_CH];
  logic [AVG_W-1:0]   avg_q [NUM_CH];
  logic [AVG_W-1:0]   avg_d [NUM_CH];
  logic [AVG_W-1:0]   peak_q, peak_d;
  logic [AVG_W-1:0]   target_q, target_d;
  logic [TIMER_W-1:0] timer_q, timer_d, timer_inc;
  logic signed [AVG_W:0] cur_s, lim_s;
  mode_e              mode_q, mode_d;
  logic [PINS_W-1:0]  pins_d;
  logic               adv;

  logic               res_valid_q;
  logic [PINS_W-1:0]  res_pins_q;
  mode_e              res_mode_q;
  logic               res_avg_valid_q;
  logic [AVG_W-1:0]   res_avg_q [NUM_CH];
  logic [AVG_W-1:0]   res_peak_q;

  assign adv    = ctl_i.valid && (!res_valid_q || result_o.ready);
  assign take_o = adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_samples_q  <= SEARCH_SAMPLES_RST;
      approach_margin_q <= APPROACH_MARGIN_RST;
      stop_threshold_q  <= STOP_THRESHOLD_RST;
      turn_pattern_q    <= TURN_PATTERN_RST;
      drive_pattern_q   <= DRIVE_PATTERN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEARCH_SAMPLES:  search_samples_q  <= cfg_wdata_i[TIMER_W-1:0];
        CFG_APPROACH_MARGIN: approach_margin_q <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_STOP_THRESHOLD:  stop_threshold_q  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_TURN_PATTERN:    turn_pattern_q    <= cfg_wdata_i[PINS_W-1:0];
        CFG_DRIVE_PATTERN:   drive_pattern_q   <= cfg_wdata_i[PINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch]  = PROD_W'(sum_i[ch]) * PROD_W'(RECIP_C);
      avg_d[ch] = ctl_i.blk_done ? AVG_W'(prod[ch][SHIFT +: EFF_BITS]) : avg_q[ch];
    end
  end

  assign peak_d    = (ctl_i.blk_done && (avg_d[1] > peak_q)) ? avg_d[1] : peak_q;
  assign timer_inc = (timer_q != '1) ? timer_q + 1'b1 : timer_q;
  assign cur_s     = $signed({1'b0, avg_d[1]});
  assign lim_s     = $signed({1'b0, target_q}) - $signed({1'b0, approach_margin_q});

  always_comb begin
    mode_d   = mode_q;
    target_d = target_q;
    timer_d  = timer_q;
    unique case (mode_q)
      MODE_SEARCH: begin
        timer_d = timer_inc;
        // a zero length acts as one since the timer is at least one here
        if (timer_inc >= search_samples_q) begin
          target_d = peak_d;
          timer_d  = '0;
          mode_d   = MODE_SPIN;
        end
      end
      MODE_SPIN: begin
        if (cur_s > lim_s) begin
          mode_d = MODE_GO;
        end
      end
      MODE_GO: begin
        if (avg_d[2] > stop_threshold_q) begin
          mode_d = MODE_DONE;
        end
      end
      MODE_DONE: ;
      default: ;
    endcase
    unique case (mode_d)
      MODE_SEARCH, MODE_SPIN: pins_d = turn_pattern_q;
      MODE_GO:                pins_d = drive_pattern_q;
      default:                pins_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEARCH;
    end else if (adv) begin
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q   <= '0;
      target_q <= '0;
      timer_q  <= '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        avg_q[ch] <= '0;
      end
    end else if (adv) begin
      peak_q   <= peak_d;
      target_q <= target_d;
      timer_q  <= timer_d;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        avg_q[ch] <= avg_d[ch];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_pins_q      <= pins_d;
      res_mode_q      <= mode_d;
      res_avg_valid_q <= ctl_i.blk_done;
      res_peak_q      <= peak_d;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        res_avg_q[ch] <= avg_d[ch];
      end
    end
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.motor_pins = res_pins_q;
  assign result_o.mode       = res_mode_q;
  assign result_o.avg_valid  = res_avg_valid_q;
  assign result_o.avg_ch0    = res_avg_q[0];
  assign result_o.avg_ch1    = res_avg_q[1];
  assign result_o.avg_ch2    = res_avg_q[2];
  assign result_o.avg_ch3    = res_avg_q[3];
  assign result_o.peak_value = res_peak_q;

  `ASC_ASSERT_NEXT(a_done_sticky, mode_q == MODE_DONE, mode_q == MODE_DONE,
                   "done mode left without reset")
  `ASC_ASSERT_NEXT(a_peak_mono, 1'b1, peak_q >= $past(peak_q), "peak decreased")
  `ASC_ASSERT_IMPLY(a_timer_search, mode_q != MODE_SEARCH, timer_q == '0,
                    "search timer running outside search")

endmodule

`default_nettype wire

// File: sv/averaged_sensor_seek_controller_top.sv
// top level of the averaged sensor seek controller
//
// sample_i carries one item per adc sampling event: one 12-bit sample of each of
// four channels. every accepted item yields exactly one item on result_o with the
// motor pin pattern, the mode after this item, a flag for a completed averaging
// block, the four latest block averages and the channel one peak.
// the result passes through the accumulator register, then the result register,
// before it is valid; one item is accepted every cycle while the receiver keeps
// up, each stage being a single add or reciprocal multiply per channel.
// sample_i.ready stays high while the result register is empty or being taken, so
// a result waiting on a stalled receiver still lets one more item into the
// accumulator stage; further items wait until result_o.ready returns.
// cfg_we_i writes register cfg_idx_i (search length, approach margin, stop
// threshold, turn pattern, drive pattern); unknown indexes are ignored. writes
// take effect from the next item and are meant for idle periods.
// reset clears sums, averages, peak, target and timer, enters search mode and
// loads the default register values; nothing is in flight afterwards.
`default_nettype none

module averaged_sensor_seek_controller_top import asc_pkg::*; #(
  parameter int unsigned BLOCK_LEN   = 10,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  asc_sample_if.sink                 sample_i,
  asc_result_if.source               result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int unsigned SUM_W    = EFF_BITS + $clog2(BLOCK_LEN);

  acc_ctl_t         acc_ctl;
  logic [SUM_W-1:0] acc_sum [NUM_CH];
  logic             take;

  asc_accum #(
    .BLOCK_LEN   (BLOCK_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .take_i   (take),
    .ctl_o    (acc_ctl),
    .sum_o    (acc_sum)
  );

  asc_seek #(
    .BLOCK_LEN   (BLOCK_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seek (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (acc_ctl),
    .sum_i       (acc_sum),
    .take_o      (take),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// File: verif/asc_seek_checker.sv
// checker for the seek controller: predicts each status item and compares it with the block
module asc_seek_checker import asc_pkg::*; #(
  parameter int unsigned BLOCK_LEN = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  asc_sample_if                 smp_i,
  asc_result_if                 res_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           fail_cnt_o,
  output int unsigned           pending_o,
  output int unsigned           results_o,
  output int unsigned           blocks_o,
  output logic [3:0]            modes_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PINS_W-1:0]            motor_pins;
    mode_e                        mode;
    logic                         avg_valid;
    logic [NUM_CH-1:0][AVG_W-1:0] avg;
    logic [AVG_W-1:0]             peak;
  } seek_status_t;

  // shadow registers
  logic [TIMER_W-1:0] search_len;
  logic [LEVEL_W-1:0] margin;
  logic [LEVEL_W-1:0] stop_level;
  logic [PINS_W-1:0]  turn_pins;
  logic [PINS_W-1:0]  drive_pins;

  // controller state as this side sees it
  logic [NUM_CH-1:0][15:0]      ch_sum;
  logic [3:0]                   blk_fill;
  logic [NUM_CH-1:0][AVG_W-1:0] ch_avg;
  logic [AVG_W-1:0]             peak;
  logic [AVG_W-1:0]             target;
  logic [TIMER_W-1:0]           search_timer;
  mode_e                        seek_mode;

  seek_status_t status_due_q[$];

  task automatic step_seeker(input logic [NUM_CH-1:0][SAMPLE_W-1:0] smp,
                             output seek_status_t st);
    st.avg_valid = 1'b0;
    for (int c = 0; c < NUM_CH; c++) ch_sum[c] = ch_sum[c] + 16'(smp[c]);
    if (blk_fill >= 4'(BLOCK_LEN - 1)) begin
      for (int c = 0; c < NUM_CH; c++) begin
        ch_avg[c] = AVG_W'(ch_sum[c] / BLOCK_LEN);
        ch_sum[c] = '0;
      end
      blk_fill = '0;
      st.avg_valid = 1'b1;
      blocks_o++;
      if (ch_avg[1] > peak) peak = ch_avg[1];
    end else begin
      blk_fill = blk_fill + 4'd1;
    end

    case (seek_mode)
      MODE_SEARCH: begin
        if (search_timer != '1) search_timer = search_timer + 1'b1;
        // a zero length ends the search on the first item
        if (search_timer >= search_len) begin
          target = peak;
          search_timer = '0;
          seek_mode = MODE_SPIN;
        end
      end
      MODE_SPIN: begin
        // limit may go negative when the margin exceeds the target
        if (int'(ch_avg[1]) > int'(target) - int'(margin)) seek_mode = MODE_GO;
      end
      MODE_GO: begin
        if (ch_avg[2] > stop_level) seek_mode = MODE_DONE;
      end
      default: ;
    endcase

    case (seek_mode)
      MODE_SEARCH, MODE_SPIN: st.motor_pins = turn_pins;
      MODE_GO:                st.motor_pins = drive_pins;
      default:                st.motor_pins = '0;
    endcase
    st.mode = seek_mode;
    st.avg  = ch_avg;
    st.peak = peak;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    seek_status_t st;
    if (!rst_ni) begin
      search_len   = SEARCH_SAMPLES_RST;
      margin       = APPROACH_MARGIN_RST;
      stop_level   = STOP_THRESHOLD_RST;
      turn_pins    = TURN_PATTERN_RST;
      drive_pins   = DRIVE_PATTERN_RST;
      ch_sum       = '0;
      blk_fill     = '0;
      ch_avg       = '0;
      peak         = '0;
      target       = '0;
      search_timer = '0;
      seek_mode    = MODE_SEARCH;
      status_due_q.delete();
      fail_cnt_o   = 0;
      pending_o    = 0;
      results_o    = 0;
      blocks_o     = 0;
      modes_seen_o = '0;
    end else begin
      if (smp_i.valid && smp_i.ready) begin
        step_seeker({smp_i.sample_ch3, smp_i.sample_ch2, smp_i.sample_ch1,
                     smp_i.sample_ch0}, st);
        status_due_q.push_back(st);
      end
      if (res_i.valid && res_i.ready) begin
        results_o++;
        if (status_due_q.size() == 0) begin
          $error("status item with no sample item waiting for it");
          fail_cnt_o++;
        end else begin
          st = status_due_q.pop_front();
          check_field("motor_pins", 16'(st.motor_pins), 16'(res_i.motor_pins));
          check_field("mode", 16'(st.mode), 16'(res_i.mode));
          check_field("avg_valid", 16'(st.avg_valid), 16'(res_i.avg_valid));
          check_field("avg_ch0", 16'(st.avg[0]), 16'(res_i.avg_ch0));
          check_field("avg_ch1", 16'(st.avg[1]), 16'(res_i.avg_ch1));
          check_field("avg_ch2", 16'(st.avg[2]), 16'(res_i.avg_ch2));
          check_field("avg_ch3", 16'(st.avg[3]), 16'(res_i.avg_ch3));
          check_field("peak_value", 16'(st.peak), 16'(res_i.peak_value));
        end
        modes_seen_o[res_i.mode] = 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEARCH_SAMPLES:  search_len = cfg_wdata_i[TIMER_W-1:0];
          CFG_APPROACH_MARGIN: margin     = cfg_wdata_i[LEVEL_W-1:0];
          CFG_STOP_THRESHOLD:  stop_level = cfg_wdata_i[LEVEL_W-1:0];
          CFG_TURN_PATTERN:    turn_pins  = cfg_wdata_i[PINS_W-1:0];
          CFG_DRIVE_PATTERN:   drive_pins = cfg_wdata_i[PINS_W-1:0];
          default: ;
        endcase
      end
      pending_o = status_due_q.size();
    end
  end

endmodule

// File: verif/tb.sv
// testbench top for the seek controller: clock, reset, stimulus, register writes and verdict
module tb;
  import asc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SAMPLE_W-1:0] FULL = '1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned n_results;
  int unsigned n_blocks;
  logic [3:0]  modes_seen;
  int unsigned n_sent;
  int          src_calm;

  asc_sample_if sample_if ();
  asc_result_if result_if ();

  averaged_sensor_seek_controller_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  asc_seek_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_i        (sample_if),
    .res_i        (result_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .results_o    (n_results),
    .blocks_o     (n_blocks),
    .modes_seen_o (modes_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle cycles before the next item, with stretches of back-to-back traffic
  function automatic int draw_idle(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic offer(input logic [SAMPLE_W-1:0] c0, input logic [SAMPLE_W-1:0] c1,
                       input logic [SAMPLE_W-1:0] c2, input logic [SAMPLE_W-1:0] c3);
    int gap;
    gap = draw_idle(src_calm);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid      <= 1'b1;
    sample_if.sample_ch0 <= c0;
    sample_if.sample_ch1 <= c1;
    sample_if.sample_ch2 <= c2;
    sample_if.sample_ch3 <= c3;
    do @(posedge clk_i); while (!sample_if.ready);
    n_sent++;
  endtask

  // seek channel capped so the phase can hold its mode
  task automatic offer_random(input int n, input int ch1_max);
    repeat (n) begin
      offer(SAMPLE_W'($urandom), SAMPLE_W'($urandom_range(0, ch1_max)),
            SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    end
  endtask

  task automatic drain();
    sample_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int stall;
    int calm;
    int rcvd;
    calm = 0;
    rcvd = 0;
    result_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // long hold-offs so the block backs up into the sample channel
      if (rcvd == 250 || rcvd == 450) stall = 60;
      else stall = draw_idle(calm);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
      rcvd++;
    end
  end

  initial begin : stimulus
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    sample_if.valid      = 1'b0;
    sample_if.sample_ch0 = '0;
    sample_if.sample_ch1 = '0;
    sample_if.sample_ch2 = '0;
    sample_if.sample_ch3 = '0;
    n_sent               = 0;
    src_calm             = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes under the reset register values
    offer('0, '0, '0, '0);
    offer(FULL, FULL, FULL, FULL);
    offer(12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA);
    offer(12'h555, 12'h555, 12'h555, 12'h555);
    offer(FULL, '0, '0, '0);
    offer('0, FULL, '0, '0);
    offer('0, '0, FULL, '0);
    offer('0, '0, '0, FULL);
    offer('0, FULL, FULL, FULL);
    offer(FULL, '0, FULL, FULL);
    offer(FULL, FULL, '0, FULL);
    offer(FULL, FULL, FULL, '0);
    offer_random(8, 4095);
    drain();

    // longest search; spare indexes must not disturb anything
    write_reg(CFG_SEARCH_SAMPLES, 16'hFFFF);
    write_reg(CFG_TURN_PATTERN, 16'd127);
    write_reg(CFG_APPROACH_MARGIN, 16'd0);
    write_reg(CFG_STOP_THRESHOLD, 16'd4095);
    for (int i = int'(CFG_DRIVE_PATTERN) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), 16'h0001);
    end
    offer_random(150, 4095);
    drain();

    // zero length ends the search at once; low seek readings keep it spinning
    write_reg(CFG_SEARCH_SAMPLES, 16'd0);
    write_reg(CFG_TURN_PATTERN, 16'd0);
    offer_random(100, 1023);
    drain();

    // margin above the target makes the limit negative
    write_reg(CFG_APPROACH_MARGIN, 16'hFFFF);
    write_reg(CFG_DRIVE_PATTERN, 16'd127);
    write_reg(CFG_TURN_PATTERN, 16'($urandom_range(0, 127)));
    offer_random(70, 4095);
    // two blocks' worth of full-scale seek readings drive the peak to the top
    repeat (20) offer(SAMPLE_W'($urandom), FULL, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    offer_random(60, 4095);
    drain();

    write_reg(CFG_DRIVE_PATTERN, 16'd0);
    write_reg(CFG_STOP_THRESHOLD, 16'd2500);
    offer_random(100, 4095);
    drain();

    // upper data bits are dropped, leaving a zero threshold
    write_reg(CFG_STOP_THRESHOLD, 16'hF000);
    write_reg(CFG_DRIVE_PATTERN, 16'($urandom_range(0, 127)));
    offer_random(80, 4095);
    drain();
    repeat (10) @(posedge clk_i);

    $display("run covered %0d sample items, %0d status items, %0d averaging blocks",
             n_sent, n_results, n_blocks);
    $display("modes reached (done go spin search) %b, %0d mismatches", modes_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("averaged_sensor_seek_controller_top test passed");
    end else begin
      $display("averaged_sensor_seek_controller_top test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("averaged_sensor_seek_controller_top test failed");
    $finish;
  end

endmodule
